// ----- sv/ctcg_pkg.sv -----
// ----------------------------------------------------------------------------
// ctcg_pkg
// Shared types and constants of the greedy CTC decoder.
// ----------------------------------------------------------------------------
package ctcg_pkg;

    localparam int MAX_CLASSES_DEF     = 8192;
    localparam int LOGIT_WIDTH_DEF     = 16;
    localparam int EXP_TABLE_DEPTH_DEF = 1024;

    localparam int CFG_W       = 14;
    localparam int CONF_W      = 16;
    localparam int SUM_W       = 32;
    localparam logic [CFG_W-1:0] NUM_CLASSES_RST = 14'd5531;
    localparam logic [CFG_W-1:0] KEY_COUNT_RST   = 14'd5531;

    // Configuration register indexes.
    typedef enum logic {
        CFG_NUM_CLASSES = 1'b0,
        CFG_KEY_COUNT   = 1'b1
    } cfg_index_t;

    // Classification that the front end attaches to every logit.
    typedef struct packed {
        logic first;
        logic last;
        logic eol;
    } item_tag_t;

endpackage

// ----- sv/ctc_greedy_decoder.sv -----
// ----------------------------------------------------------------------------
// ctc_greedy_decoder
// Greedy CTC decoder with softmax confidence over a stream of Q5.10 logits.
//
//   channel   ports                                              direction
//   input     push, full, logit, end_of_line                     in
//   result    pop, empty, char_index, confidence, char_valid,    out
//             line_end
//   config    cfg_write, cfg_index, cfg_data                     in
//
// In the row engine each logit passes a table read of the exponential in
// S_IDLE, then the sum update with its 32x17 multiply in S_ACC, before the next.
// A row end that closes a line without a character then passes S_OUT; one
// that emits a character passes S_START, S_DIV and S_OUT, waiting in S_DIV
// for the 33-step divider that forms the confidence.
// Reset is asynchronous; no clearing pass follows it.
// Queues of two beats on both sides let input and result sides stall freely.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder #(
    parameter int MAX_CLASSES     = ctcg_pkg::MAX_CLASSES_DEF,
    parameter int LOGIT_WIDTH     = ctcg_pkg::LOGIT_WIDTH_DEF,
    parameter int EXP_TABLE_DEPTH = ctcg_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [LOGIT_WIDTH-1:0] logit,
    input  logic                          end_of_line,
    output logic                          empty,
    input  logic                          pop,
    output logic [$clog2(MAX_CLASSES)-1:0] char_index,
    output logic [ctcg_pkg::CONF_W-1:0]   confidence,
    output logic                          char_valid,
    output logic                          line_end,
    input  logic                          cfg_write,
    input  ctcg_pkg::cfg_index_t          cfg_index,
    input  logic [ctcg_pkg::CFG_W-1:0]    cfg_data
);
    import ctcg_pkg::*;

    localparam int COL_W  = $clog2(MAX_CLASSES);
    localparam int IQ_W   = LOGIT_WIDTH + COL_W + $bits(item_tag_t);
    localparam int OQ_W   = COL_W + CONF_W + 2;

    logic [CFG_W-1:0]       num_classes_reg, key_count_reg;
    logic                   fq_push, fq_full, fq_empty, fq_pop;
    logic [LOGIT_WIDTH-1:0] f_logit, b_logit;
    logic [COL_W-1:0]       f_col, b_col;
    item_tag_t              f_tag, b_tag;
    logic [IQ_W-1:0]        fq_rdata;
    logic                   oq_push, oq_full;
    logic [COL_W-1:0]       r_index;
    logic [CONF_W-1:0]      r_conf;
    logic                   r_valid, r_end;
    logic [OQ_W-1:0]        oq_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg <= NUM_CLASSES_RST;
            key_count_reg   <= KEY_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUM_CLASSES: num_classes_reg <= cfg_data;
                CFG_KEY_COUNT:   key_count_reg   <= cfg_data;
                default:         num_classes_reg <= num_classes_reg;
            endcase
        end
    end

    ctcg_front #(
        .LOGIT_WIDTH (LOGIT_WIDTH),
        .MAX_CLASSES (MAX_CLASSES),
        .COL_W       (COL_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .logit       (logit),
        .end_of_line (end_of_line),
        .full        (full),
        .num_classes (num_classes_reg),
        .q_push      (fq_push),
        .q_logit     (f_logit),
        .q_col       (f_col),
        .q_tag       (f_tag),
        .q_full      (fq_full)
    );

    ctcg_fifo #(
        .WIDTH (IQ_W),
        .DEPTH (2)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata ({f_logit, f_col, f_tag}),
        .full  (fq_full),
        .pop   (fq_pop),
        .rdata (fq_rdata),
        .empty (fq_empty)
    );

    assign {b_logit, b_col, b_tag} = fq_rdata;

    ctcg_back #(
        .LOGIT_WIDTH     (LOGIT_WIDTH),
        .COL_W           (COL_W),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (fq_empty),
        .q_pop          (fq_pop),
        .q_logit        (b_logit),
        .q_col          (b_col),
        .q_tag          (b_tag),
        .key_count      (key_count_reg),
        .oq_full        (oq_full),
        .oq_push        (oq_push),
        .res_char_index (r_index),
        .res_confidence (r_conf),
        .res_char_valid (r_valid),
        .res_line_end   (r_end)
    );

    ctcg_fifo #(
        .WIDTH (OQ_W),
        .DEPTH (2)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .wdata ({r_index, r_conf, r_valid, r_end}),
        .full  (oq_full),
        .pop   (pop),
        .rdata (oq_rdata),
        .empty (empty)
    );

    assign {char_index, confidence, char_valid, line_end} = oq_rdata;
endmodule

// ----- sv/ctcg_fifo.sv -----
// ----------------------------------------------------------------------------
// ctcg_fifo
// Small synchronous queue with full and empty flags.
// ----------------------------------------------------------------------------
module ctcg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

// ----- sv/ctcg_front.sv -----
// ----------------------------------------------------------------------------
// ctcg_front
// Accepts logits, counts columns and tags row start, row end and line end.
// ----------------------------------------------------------------------------
module ctcg_front #(
    parameter int LOGIT_WIDTH = 16,
    parameter int MAX_CLASSES = 8192,
    parameter int COL_W       = 13
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic signed [LOGIT_WIDTH-1:0] logit,
    input  logic                         end_of_line,
    output logic                         full,
    input  logic [ctcg_pkg::CFG_W-1:0]   num_classes,
    output logic                         q_push,
    output logic [LOGIT_WIDTH-1:0]       q_logit,
    output logic [COL_W-1:0]             q_col,
    output ctcg_pkg::item_tag_t          q_tag,
    input  logic                         q_full
);
    import ctcg_pkg::*;

    localparam int CNT_W = $clog2(MAX_CLASSES + 1);
    localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    logic [COL_W-1:0] col_reg, col_next;
    logic [CMP_W-1:0] n_raw, n_eff, col_plus;
    logic             accept, row_last;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        n_raw = CMP_W'(num_classes);
        if (n_raw == '0)
        begin
            n_eff = CMP_W'(1);
        end
        else if (n_raw > CMP_W'(MAX_CLASSES))
        begin
            n_eff = CMP_W'(MAX_CLASSES);
        end
        else
        begin
            n_eff = n_raw;
        end
        col_plus = CMP_W'(col_reg) + CMP_W'(1);
        row_last = (col_plus >= n_eff) || end_of_line;
        col_next = row_last ? '0 : COL_W'(col_plus);
    end

    assign q_push      = accept;
    assign q_logit     = logit;
    assign q_col       = col_reg;
    assign q_tag.first = (col_reg == '0);
    assign q_tag.last  = row_last;
    assign q_tag.eol   = end_of_line;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
        end
    end
endmodule

// ----- sv/ctcg_div.sv -----
// ----------------------------------------------------------------------------
// ctcg_div
// Restoring divider for 2^32 / sum, one quotient bit per cycle, saturated
// to 16 bits.
// ----------------------------------------------------------------------------
module ctcg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ctcg_pkg::SUM_W-1:0]  divisor,
    output logic                        done,
    output logic [ctcg_pkg::CONF_W-1:0] quotient
);
    import ctcg_pkg::*;

    localparam int STEPS = SUM_W + 1;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic [SUM_W-1:0]  div_reg;
    logic [SUM_W:0]    rem_reg, rem_shift;
    logic [SUM_W:0]    quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg, done_reg, bit_in, ge;

    // The dividend is a one followed by zeros, so only the first step shifts in a one.
    assign bit_in    = (step_reg == STEP_W'(STEPS));
    assign rem_shift = {rem_reg[SUM_W-1:0], bit_in};
    assign ge        = rem_shift >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(STEPS);
                rem_reg  <= '0;
                quo_reg  <= '0;
                div_reg  <= (divisor == '0) ? SUM_W'(1) : divisor;
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? rem_shift - {1'b0, div_reg} : rem_shift;
                quo_reg  <= {quo_reg[SUM_W-1:0], ge};
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = (quo_reg > (SUM_W + 1)'(16'hFFFF)) ? 16'hFFFF : quo_reg[CONF_W-1:0];
endmodule

// ----- sv/ctcg_back.sv -----
// ----------------------------------------------------------------------------
// ctcg_back
// Row engine: running maximum, online softmax sum, row decision and result.
// ----------------------------------------------------------------------------
module ctcg_back #(
    parameter int LOGIT_WIDTH     = 16,
    parameter int COL_W           = 13,
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  logic [LOGIT_WIDTH-1:0]      q_logit,
    input  logic [COL_W-1:0]            q_col,
    input  ctcg_pkg::item_tag_t         q_tag,
    input  logic [ctcg_pkg::CFG_W-1:0]  key_count,
    input  logic                        oq_full,
    output logic                        oq_push,
    output logic [COL_W-1:0]            res_char_index,
    output logic [ctcg_pkg::CONF_W-1:0] res_confidence,
    output logic                        res_char_valid,
    output logic                        res_line_end
);
    import ctcg_pkg::*;

    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam int DW    = LOGIT_WIDTH + 1;
    localparam int AW    = DW + 14;
    localparam int PW    = 14 + IDX_W;
    localparam int KW    = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
    localparam logic [SUM_W-1:0] ONE = 32'h0001_0000;

    typedef logic [16:0] rom_t [EXP_TABLE_DEPTH];

    // Shift-and-subtract quotient, used only while the table is built.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem, quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-16k/DEPTH) in Q1.16 from a Q30 series, reciprocal and four squarings.
    function automatic rom_t build_rom();
        rom_t        r;
        logic [63:0] s, term, sum, q, n;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++)
        begin
            s    = udiv64(64'(k) << 30, 64'(EXP_TABLE_DEPTH));
            term = 64'd1 << 30;
            sum  = term;
            for (n = 64'd1; n < 64'd48 && term != 64'd0; n++)
            begin
                term = udiv64((term * s) >> 30, n);
                sum  = sum + term;
            end
            q = udiv64(64'd1 << 60, sum);
            for (int j = 0; j < 4; j++)
            begin
                q = (q * q + (64'd1 << 29)) >> 30;
            end
            r[k] = 17'((q + (64'd1 << 13)) >> 14);
        end
        return r;
    endfunction

    localparam rom_t EXP_ROM = build_rom();

    typedef enum logic [1:0] {MODE_FIRST, MODE_RESCALE, MODE_ADD} mode_t;
    typedef enum logic [2:0] {S_IDLE, S_ACC, S_START, S_DIV, S_OUT} state_t;

    state_t                  state_reg;
    mode_t                   mode_reg;
    item_tag_t               tag_reg;
    logic signed [LOGIT_WIDTH-1:0] max_reg, x;
    logic [COL_W-1:0]        best_reg, prev_reg;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [16:0]             rom_q_reg, e;
    logic                    ezero_reg, gt, big, emit;
    logic signed [DW-1:0]    diff;
    logic [AW-1:0]           dabs;
    logic [PW-1:0]           prod;
    logic [IDX_W-1:0]        idx;
    logic [SUM_W+16:0]       mprod;
    logic [SUM_W+1:0]        rescaled;
    logic [SUM_W:0]          added;
    logic                    div_start, div_done;
    logic [CONF_W-1:0]       div_q;
    logic [CONF_W-1:0]       conf_reg;

    assign x    = signed'(q_logit);
    assign gt   = x > max_reg;
    assign diff = gt ? ({x[LOGIT_WIDTH-1], x} - {max_reg[LOGIT_WIDTH-1], max_reg})
                     : ({max_reg[LOGIT_WIDTH-1], max_reg} - {x[LOGIT_WIDTH-1], x});
    assign dabs = AW'($unsigned(diff));
    assign big  = dabs >= AW'(16384);
    assign prod = PW'(dabs[13:0]) * PW'(EXP_TABLE_DEPTH);
    assign idx  = prod[PW-1:14];

    assign e        = ezero_reg ? 17'd0 : rom_q_reg;
    assign mprod    = (SUM_W + 17)'(sum_reg) * (SUM_W + 17)'(e);
    assign rescaled = (SUM_W + 2)'(mprod[SUM_W+16:16]) + (SUM_W + 2)'(ONE);
    assign added    = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(e);

    always_comb
    begin
        case (mode_reg)
            MODE_FIRST:   sum_next = ONE;
            MODE_RESCALE: sum_next = (rescaled[SUM_W+1:SUM_W] != 2'b00) ? '1
                                                                      : rescaled[SUM_W-1:0];
            MODE_ADD:     sum_next = added[SUM_W] ? '1 : added[SUM_W-1:0];
            default:      sum_next = sum_reg;
        endcase
    end

    // best_reg already holds this row's winner when the last element is added up.
    assign emit = (best_reg != '0) && (KW'(best_reg) < KW'(key_count)) && (best_reg != prev_reg);

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign div_start = (state_reg == S_START);
    assign oq_push   = (state_reg == S_OUT) && !oq_full;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rom_q_reg <= EXP_ROM[idx];
            ezero_reg <= big;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_FIRST;
            tag_reg        <= '0;
            max_reg        <= '0;
            best_reg       <= '0;
            prev_reg       <= '0;
            sum_reg        <= '0;
            conf_reg       <= '0;
            res_char_index <= '0;
            res_confidence <= '0;
            res_char_valid <= 1'b0;
            res_line_end   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        tag_reg <= q_tag;
                        if (q_tag.first)
                        begin
                            mode_reg <= MODE_FIRST;
                            max_reg  <= x;
                            best_reg <= '0;
                        end
                        else if (gt)
                        begin
                            mode_reg <= MODE_RESCALE;
                            max_reg  <= x;
                            best_reg <= q_col;
                        end
                        else
                        begin
                            mode_reg <= MODE_ADD;
                        end
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    sum_reg <= sum_next;
                    if (tag_reg.last)
                    begin
                        prev_reg       <= tag_reg.eol ? '0 : best_reg;
                        res_char_index <= emit ? best_reg - 1'b1 : '0;
                        res_char_valid <= emit;
                        res_line_end   <= tag_reg.eol;
                        res_confidence <= '0;
                        if (emit)
                        begin
                            state_reg <= S_START;
                        end
                        else if (tag_reg.eol)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        conf_reg       <= div_q;
                        res_confidence <= div_q;
                        state_reg      <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!oq_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    ctcg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // A row that reaches the divider always has a sum of at least one.
    a_sum_floor: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (sum_reg >= ONE))
        else $error("row sum below one at divide");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> (res_char_valid || res_line_end))
        else $error("empty result pushed");

    a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_done) |=> (state_reg == S_OUT && res_confidence == conf_reg))
        else $error("divider result lost");

    a_conf_only_char: assert property (@(posedge clk) disable iff (!rst_n)
        (oq_push && !res_char_valid) |-> (res_confidence == '0 && res_char_index == '0))
        else $error("confidence on a line close without character");
endmodule
